@@ hw/rtl/jsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared codes, types and helpers for the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam logic [1:0] MODE_REGULAR = 2'd0;
  localparam logic [1:0] MODE_ESCAPED = 2'd1;
  localparam logic [1:0] MODE_HEX     = 2'd2;

  localparam logic [2:0] ST_CONTINUE = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_CTRL     = 3'd2;
  localparam logic [2:0] ST_ESCAPE   = 3'd3;
  localparam logic [2:0] ST_HEX      = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;
  localparam logic [2:0] ST_SURR     = 3'd6;
  localparam logic [2:0] ST_UNTERM   = 3'd7;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CTRL_MAX     = 8'h1F;

  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0C;
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;
  localparam logic [7:0] HT_CODE = 8'h09;

  localparam logic [15:0] CP_ONE_MAX  = 16'h007F;
  localparam logic [15:0] CP_TWO_MAX  = 16'h07FF;
  localparam logic [15:0] CP_SURR_LO  = 16'hD800;
  localparam logic [15:0] CP_SURR_HI  = 16'hDFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic        failed;
    logic [1:0]  hex_count;
    logic [11:0] hex_value;
  } jsu_state_t;

  // Everything one input word produces: up to three bytes and a status.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic [2:0] status;
  } jsu_burst_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/jsu_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and output decode for one string body byte.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  wire logic [7:0] in_byte,
  input  wire logic       in_ended,
  input  wire jsu_state_t cur,
  output jsu_state_t      nxt,
  output jsu_burst_t      burst
);

  logic [4:0]  hd;
  logic [15:0] cp;

  assign hd = hex_digit(in_byte);
  assign cp = {cur.hex_value, hd[3:0]};

  always_comb begin
    nxt   = cur;
    burst = '0;
    burst.status = ST_CONTINUE;
    if (cur.failed) begin
      burst.status = ST_UNTERM;
    end else if (in_ended) begin
      nxt = '0;
      nxt.failed = 1'b1;
      burst.status = ST_UNTERM;
    end else begin
      case (cur.mode)
        MODE_ESCAPED: begin
          nxt.mode = MODE_REGULAR;
          burst.nbytes = 2'd1;
          case (in_byte)
            CH_BACKSLASH, CH_SLASH, CH_QUOTE: burst.b0 = in_byte;
            CH_B: burst.b0 = BS_CODE;
            CH_F: burst.b0 = FF_CODE;
            CH_N: burst.b0 = LF_CODE;
            CH_R: burst.b0 = CR_CODE;
            CH_T: burst.b0 = HT_CODE;
            CH_U: begin
              nxt.mode      = MODE_HEX;
              nxt.hex_count = 2'd0;
              nxt.hex_value = 12'd0;
              burst.nbytes  = 2'd0;
            end
            default: begin
              nxt = '0;
              nxt.failed   = 1'b1;
              burst.nbytes = 2'd0;
              burst.status = ST_ESCAPE;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hd[4]) begin
            nxt = '0;
            nxt.failed   = 1'b1;
            burst.status = ST_HEX;
          end else if (cur.hex_count != 2'd3) begin
            nxt.hex_value = cp[11:0];
            nxt.hex_count = cur.hex_count + 2'd1;
          end else begin
            nxt = '0;
            if (cp == 16'd0) begin
              nxt.failed   = 1'b1;
              burst.status = ST_ZERO;
            end else if (cp <= CP_ONE_MAX) begin
              burst.b0     = cp[7:0];
              burst.nbytes = 2'd1;
            end else if (cp <= CP_TWO_MAX) begin
              burst.b0     = {3'b110, cp[10:6]};
              burst.b1     = {2'b10, cp[5:0]};
              burst.nbytes = 2'd2;
            end else if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
              nxt.failed   = 1'b1;
              burst.status = ST_SURR;
            end else begin
              burst.b0     = {4'b1110, cp[15:12]};
              burst.b1     = {2'b10, cp[11:6]};
              burst.b2     = {2'b10, cp[5:0]};
              burst.nbytes = 2'd3;
            end
          end
        end
        default: begin
          // Regular mode; the spare mode code behaves the same way.
          nxt.mode = MODE_REGULAR;
          if (in_byte == CH_QUOTE) begin
            burst.status = ST_DONE;
          end else if (in_byte == CH_BACKSLASH) begin
            nxt.mode = MODE_ESCAPED;
          end else if (in_byte <= CTRL_MAX) begin
            nxt = '0;
            nxt.failed   = 1'b1;
            burst.status = ST_CTRL;
          end else begin
            burst.b0     = in_byte;
            burst.nbytes = 2'd1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/json_string_unescape_unit.sv @@
`default_nettype none
// Latency: the first result word of an input word is registered and is on the
// output in the cycle after the input is accepted.
// Throughput: one input word per cycle while each yields one result word and
// the output is not stalled; a \u escape that encodes to two or three UTF-8
// bytes holds the single result register while it drains one word per cycle.
// Reset (synchronous, active low) returns to regular mode and clears the error.
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Decodes a JSON string body byte stream into raw bytes with status words.
// ----------------------------------------------------------------------------
module json_string_unescape_unit import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_input_ended,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last,
  output logic [2:0]      out_status
);

  jsu_state_t state_r, state_nxt;
  jsu_burst_t burst_r, burst_nxt;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       take, take_last, accept;

  jsu_decode u_decode (
    .in_byte  (in_byte),
    .in_ended (in_input_ended),
    .cur      (state_r),
    .nxt      (state_nxt),
    .burst    (burst_nxt)
  );

  assign out_valid = busy_r;
  assign out_byte_valid = (burst_r.nbytes != 2'd0);
  assign out_last = (burst_r.nbytes == 2'd0) || (idx_r == burst_r.nbytes - 2'd1);
  assign out_status = out_last ? burst_r.status : ST_CONTINUE;

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = burst_r.b0;
      2'd1:    out_byte = burst_r.b1;
      default: out_byte = burst_r.b2;
    endcase
    if (!out_byte_valid) begin
      out_byte = 8'd0;
    end
  end

  assign take      = busy_r && !out_stall;
  assign take_last = take && out_last;
  // A new word may load as the last word of the current burst leaves.
  assign in_stall  = busy_r && !take_last;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      busy_r  <= 1'b0;
      idx_r   <= 2'd0;
    end else if (accept) begin
      state_r <= state_nxt;
      busy_r  <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take_last) begin
      busy_r  <= 1'b0;
    end else if (take) begin
      idx_r   <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      burst_r <= burst_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/jsu_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_port_props
// Port-level checks on the result stream of the unescape unit.
// ----------------------------------------------------------------------------
module jsu_port_props import jsu_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_last,
  input wire logic [2:0] out_status
);

  logic failed_seen_r;

  // Remembers that an error status has been delivered since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_last && out_status != ST_CONTINUE
                 && out_status != ST_DONE) begin
      failed_seen_r <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_status)
      && $stable(out_last) && $stable(out_byte_valid))
    else $error("stalled result word changed");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && out_byte == 8'd0)
    else $error("word without a byte is not a lone last word");

  a_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte_valid && out_status == ST_CONTINUE)
    else $error("non-final word carries no byte or a status");

  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_status == ST_CONTINUE)
    else $error("decoded byte arrives with a final status");

  a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && failed_seen_r |-> !out_byte_valid && out_last && out_status == ST_UNTERM)
    else $error("output after an error is not the stuck status");

endmodule

bind json_string_unescape_unit jsu_port_props u_jsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_last       (out_last),
  .out_status     (out_status)
);
`default_nettype wire

@@ sim/jsu_checker.sv @@
// ----------------------------------------------------------------------------
// jsu_checker
// Watches both channels of the JSON string unescape unit, decodes every
// accepted input word on its own, and compares each result word in order.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_input_ended,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_last,
  input  logic [2:0] out_status,
  output int         n_fail,
  output int         n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_F = 8'h66;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_F = 8'h46;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       last;
    logic [2:0] status;
  } dec_result_t;

  dec_result_t decoded_q[$];

  logic [1:0]  dec_mode;
  logic        dec_failed;
  logic [1:0]  dec_count;
  logic [11:0] dec_value;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= DIGIT_0 && c <= DIGIT_9) return int'(c - DIGIT_0);
    if (c >= LOWER_A && c <= LOWER_F) return int'(c - LOWER_A) + 10;
    if (c >= UPPER_A && c <= UPPER_F) return int'(c - UPPER_A) + 10;
    return -1;
  endfunction

  // Decodes one accepted word and queues the result words it must produce.
  task automatic decode_word(input logic [7:0] c, input logic ended);
    logic [7:0]  bytes [3];
    int          nb;
    int          d;
    logic        bad;
    logic [2:0]  st;
    logic [15:0] cp;
    dec_result_t r;
    nb  = 0;
    bad = 1'b0;
    st  = ST_CONTINUE;
    if (dec_failed) begin
      st = ST_UNTERM;
    end else if (ended) begin
      st  = ST_UNTERM;
      bad = 1'b1;
    end else begin
      case (dec_mode)
        MODE_ESCAPED: begin
          dec_mode = MODE_REGULAR;
          nb = 1;
          case (c)
            CH_BACKSLASH, CH_SLASH, CH_QUOTE: bytes[0] = c;
            CH_B: bytes[0] = BS_CODE;
            CH_F: bytes[0] = FF_CODE;
            CH_N: bytes[0] = LF_CODE;
            CH_R: bytes[0] = CR_CODE;
            CH_T: bytes[0] = HT_CODE;
            CH_U: begin
              nb        = 0;
              dec_mode  = MODE_HEX;
              dec_count = 2'd0;
              dec_value = 12'd0;
            end
            default: begin
              nb  = 0;
              st  = ST_ESCAPE;
              bad = 1'b1;
            end
          endcase
        end
        MODE_HEX: begin
          d = nibble_of(c);
          if (d < 0) begin
            st  = ST_HEX;
            bad = 1'b1;
          end else if (dec_count < 2'd3) begin
            dec_value = {dec_value[7:0], 4'(d)};
            dec_count = dec_count + 2'd1;
          end else begin
            cp        = {dec_value, 4'(d)};
            dec_count = 2'd0;
            dec_value = 12'd0;
            dec_mode  = MODE_REGULAR;
            if (cp == 16'd0) begin
              st  = ST_ZERO;
              bad = 1'b1;
            end else if (cp <= CP_ONE_MAX) begin
              bytes[0] = cp[7:0];
              nb = 1;
            end else if (cp <= CP_TWO_MAX) begin
              bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
              bytes[1] = 8'h80 | {2'd0, cp[5:0]};
              nb = 2;
            end else if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
              st  = ST_SURR;
              bad = 1'b1;
            end else begin
              bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
              bytes[1] = 8'h80 | {2'd0, cp[11:6]};
              bytes[2] = 8'h80 | {2'd0, cp[5:0]};
              nb = 3;
            end
          end
        end
        default: begin
          // The unused mode code behaves like regular mode.
          dec_mode = MODE_REGULAR;
          if (c == CH_QUOTE) begin
            st = ST_DONE;
          end else if (c == CH_BACKSLASH) begin
            dec_mode = MODE_ESCAPED;
          end else if (c <= CTRL_MAX) begin
            st  = ST_CTRL;
            bad = 1'b1;
          end else begin
            bytes[0] = c;
            nb = 1;
          end
        end
      endcase
    end
    if (bad) begin
      dec_failed = 1'b1;
      dec_mode   = MODE_REGULAR;
      dec_count  = 2'd0;
      dec_value  = 12'd0;
    end
    if (nb == 0) begin
      r = '{data: 8'd0, data_ok: 1'b0, last: 1'b1, status: st};
      decoded_q.insert(decoded_q.size(), r);
    end else begin
      for (int i = 0; i < nb; i++) begin
        r = '{data: bytes[i], data_ok: 1'b1, last: (i == nb - 1),
              status: (i == nb - 1) ? st : ST_CONTINUE};
        decoded_q.insert(decoded_q.size(), r);
      end
    end
  endtask

  // Result words are checked before the same edge's input word is decoded;
  // the unit registers its results, so the two can never belong together.
  always @(posedge clk) begin
    dec_result_t want;
    if (!rst_n) begin
      dec_mode   = MODE_REGULAR;
      dec_failed = 1'b0;
      dec_count  = 2'd0;
      dec_value  = 12'd0;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result word: out_byte %h status %0d", out_byte, out_status);
          n_fail <= n_fail + 1;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || out_byte_valid !== want.data_ok ||
              out_last !== want.last || out_status !== want.status) begin
            n_fail <= n_fail + 1;
          end
          if (out_byte !== want.data)
            $error("out_byte: expected %h, got %h", want.data, out_byte);
          if (out_byte_valid !== want.data_ok)
            $error("out_byte_valid: expected %b, got %b", want.data_ok, out_byte_valid);
          if (out_last !== want.last)
            $error("out_last: expected %b, got %b", want.last, out_last);
          if (out_status !== want.status)
            $error("out_status: expected %0d, got %0d", want.status, out_status);
        end
      end
      if (in_valid && !in_stall) begin
        decode_word(in_byte, in_input_ended);
      end
    end
    n_pending <= decoded_q.size();
  end

endmodule

@@ sim/tb_json_string_unescape_unit.sv @@
// ----------------------------------------------------------------------------
// tb_json_string_unescape_unit
// Feeds the unescape unit with well-formed string bodies full of plain bytes,
// simple escapes and \u escapes under changing back-pressure, then ends the
// run with one randomly chosen error and a few words in the stuck state.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_unit import jsu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         LIMIT_CYCLES = 200000;
  localparam logic [7:0] DIGIT_0      = 8'h30;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] UPPER_A      = 8'h41;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte        = 8'd0;
  logic       in_input_ended = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic [2:0] out_status;

  int n_fail;
  int n_pending;
  int cycles     = 0;
  int words_sent = 0;
  int snd_pct    = 0;
  int rcv_pct    = 0;

  json_string_unescape_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_input_ended (in_input_ended),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  jsu_checker i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_input_ended (in_input_ended),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status),
    .n_fail         (n_fail),
    .n_pending      (n_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (rcv_pct > 0) && ($urandom_range(99) < rcv_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the word is accepted.
  // Stall is sampled at the falling edge, where it holds its pre-edge value.
  task automatic send_word(input logic [7:0] b, input logic ended);
    int   gap;
    logic stalled;
    gap = 0;
    if (snd_pct > 0 && $urandom_range(99) < snd_pct) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_input_ended <= ended;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return DIGIT_0 + 8'(n);
    if ($urandom_range(1)) return UPPER_A + 8'(n) - 8'd10;
    return LOWER_A + 8'(n) - 8'd10;
  endfunction

  task automatic send_hex_digits(input logic [15:0] v, input int count);
    for (int i = 0; i < count; i++) begin
      send_word(hex_char(v[15 - 4 * i -: 4]), 1'b0);
    end
  endtask

  task automatic send_u(input logic [15:0] cp);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_U, 1'b0);
    send_hex_digits(cp, 4);
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(1, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  // One string body: a few chunks, then the closing quote.
  task automatic send_string();
    int         n;
    int         pick;
    logic [7:0] letter;
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_word(pick_plain(), 1'b0);
      end else if (pick < 75) begin
        case ($urandom_range(7))
          0:       letter = CH_QUOTE;
          1:       letter = CH_BACKSLASH;
          2:       letter = CH_SLASH;
          3:       letter = CH_B;
          4:       letter = CH_F;
          5:       letter = CH_N;
          6:       letter = CH_R;
          default: letter = CH_T;
        endcase
        send_word(CH_BACKSLASH, 1'b0);
        send_word(letter, 1'b0);
      end else if (pick < 95) begin
        send_u(pick_code_point());
      end else begin
        // Noise: any byte from 8'h20 to 8'hFF but a backslash, a stray quote included.
        do letter = 8'($urandom_range(8'h20, 8'hFF)); while (letter == CH_BACKSLASH);
        send_word(letter, 1'b0);
      end
    end
    send_word(CH_QUOTE, 1'b0);
  endtask

  task automatic run_phase(input int snd, input int rcv, input int upto);
    snd_pct = snd;
    rcv_pct = rcv;
    while (words_sent < upto) send_string();
  endtask

  initial begin
    int         kind;
    int         k;
    logic [7:0] b;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_pct = 6;
    rcv_pct = 70;

    // Boundaries of plain bytes, a simple escape or two, and the three
    // UTF-8 lengths at their edges.
    send_word(8'h20, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_N, 1'b0);
    send_u(16'h0001);
    send_u(16'h07FF);
    send_u(16'hFFFF);
    send_word(CH_QUOTE, 1'b0);

    run_phase(6, 70, 90);
    drain();
    run_phase(70, 6, 160);
    drain();
    run_phase(0, 0, 230);

    // Any error sticks until reset, so exactly one error ends the run.
    kind = $urandom_range(5);
    k    = $urandom_range(3);
    case (kind)
      0: begin
        send_word(8'($urandom_range(CTRL_MAX)), 1'b0);
      end
      1: begin
        do b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BACKSLASH || b == CH_SLASH || b == CH_B ||
               b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(b, 1'b0);
      end
      2: begin
        do b = 8'($urandom_range(255));
        while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66));
        send_word(CH_BACKSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_hex_digits(pick_code_point(), k);
        send_word(b, 1'b0);
      end
      3: begin
        send_u(16'h0000);
      end
      4: begin
        send_u(16'($urandom_range(CP_SURR_LO, CP_SURR_HI)));
      end
      default: begin
        // End of input in regular, escaped or hex mode.
        case ($urandom_range(2))
          0: ;
          1: send_word(CH_BACKSLASH, 1'b0);
          default: begin
            send_word(CH_BACKSLASH, 1'b0);
            send_word(CH_U, 1'b0);
            send_hex_digits(pick_code_point(), k);
          end
        endcase
        send_word(8'($urandom_range(255)), 1'b1);
      end
    endcase

    repeat (8) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    send_word(8'h00, 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
